// ===== rtl/bqeq_pkg.sv =====
// Shared widths, register codes and history layout for the multichannel biquad core.
// No dependencies; imported by multichannel_biquad_eq_filter_core.
package bqeq_pkg;

	localparam int MAX_CHANNELS = 6;
	localparam int SAMPLE_BITS  = 24;
	localparam int COEF_BITS    = 32;
	localparam int COEF_FRAC    = COEF_BITS - 4;
	localparam int BIAS_BITS    = 4;
	localparam int MODE_BITS    = 2;
	localparam int CHAN_BITS    = 3;
	localparam int HADDR_BITS   = $clog2(MAX_CHANNELS);
	localparam int FSIZE_BITS   = CHAN_BITS + 1;
	localparam int NUM_COEFS    = 6;
	// five products of coef x sample, each at most 2^(S+C-2) in magnitude
	localparam int ACC_BITS     = SAMPLE_BITS + COEF_BITS + 2;
	localparam int PROD_BITS    = 2 * COEF_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;

	typedef enum logic [2:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2,
		REG_RECIP_A0,
		REG_BIAS,
		REG_MODE
	} cfg_reg_t;

	localparam logic [MODE_BITS-1:0] MODE_MONO     = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_STEREO   = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_SURROUND = 2'd2;

	localparam coef_t COEF_ONE =
		{{(COEF_BITS-COEF_FRAC-1){1'b0}}, 1'b1, {COEF_FRAC{1'b0}}};

	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} hist_t;

	// Channels per frame for a mode, clipped to the history depth.
	function automatic logic [FSIZE_BITS-1:0] frame_size(input logic [MODE_BITS-1:0] mode);
		logic [FSIZE_BITS-1:0] size;
		unique case (mode)
			MODE_STEREO:   size = FSIZE_BITS'(2);
			MODE_SURROUND: size = FSIZE_BITS'(6);
			default:       size = FSIZE_BITS'(1);
		endcase
		if (size > FSIZE_BITS'(MAX_CHANNELS))
			size = FSIZE_BITS'(MAX_CHANNELS);
		return size;
	endfunction

endpackage

// ===== rtl/multichannel_biquad_eq_filter_core.sv =====
// Multichannel Direct Form I biquad core: sequencer, shared multiplier, history RAM.
// Depends on bqeq_pkg.
//
// One interleaved audio sample enters per item beat (1, 2 or 6 channels per frame, set by
// the REG_MODE register) and one filtered sample leaves per result beat, tagged with its channel,
// a frame-end flag and a copy of block_end_in. Each channel keeps x1, x2, y1, y2 in a
// six-entry history RAM with a registered read port; a per-entry valid bit makes a never
// written entry read as zero, so no clearing pass is needed after reset. A single 32x32
// signed multiplier forms b0*x, b1*x1, b2*x2, a1*y1, a2*y2 on successive cycles, the sum is
// rounded by 28 bits, multiplied by recip_a0, rounded again and saturated to 24 bits.
// Each item runs through the accept step (history read), five multiply steps, one round
// step, one scale multiply and one write-back step before the next item beat; the shared
// multiplier sets this sequence. A finished result sits in the output register,
// so the next item is taken while the previous result still waits; if the output register
// is still full at write-back, the core holds there. Configuration writes are always
// taken (cfg_ready is tied high) and must only be issued while the core is idle.
module multichannel_biquad_eq_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  bqeq_pkg::cfg_reg_t                  cfg_index,
	input  logic [bqeq_pkg::COEF_BITS-1:0]      cfg_data,
	// sample item channel
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic signed [bqeq_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                block_end_in,
	// filtered result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [bqeq_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [bqeq_pkg::CHAN_BITS-1:0]      channel_index,
	output logic                                frame_end,
	output logic                                block_end_out
);
	import bqeq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_RND,
		ST_SCALE,
		ST_OUT
	} state_t;

	localparam logic [2:0] LAST_STEP = 3'd4;
	localparam logic signed [ACC_BITS-1:0]  ACC_HALF  = ACC_BITS'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [PROD_BITS-1:0] PROD_HALF = PROD_BITS'(1) <<< (COEF_FRAC - 1);
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// control state
	state_t                  state_q;
	logic [2:0]              step_q;
	logic [CHAN_BITS-1:0]    chan_cnt_q;
	logic                    bias_neg_q;
	logic [MAX_CHANNELS-1:0] hist_vld_q;
	logic                    rd_vld_q;

	// configuration registers
	coef_t                   coef_q [NUM_COEFS];
	logic [BIAS_BITS-1:0]    bias_mag_q;
	logic [MODE_BITS-1:0]    mode_q;

	// result register
	logic                    res_vld_q;
	sample_t                 res_sample_q;
	logic [CHAN_BITS-1:0]    res_chan_q;
	logic                    res_fend_q;
	logic                    res_blk_q;

	// datapath registers
	sample_t                 x_q;
	logic [CHAN_BITS-1:0]    ch_q;
	logic                    fend_q;
	logic                    blk_q;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [PROD_BITS-1:0] prod_s1;
	coef_t                   num_q;

	// history RAM
	hist_t                   hist_mem [MAX_CHANNELS];
	hist_t                   hist_rd_q;
	hist_t                   hist;
	hist_t                   hist_wdata;
	logic                    hist_we;
	logic                    hist_re;
	logic [HADDR_BITS-1:0]   rd_addr;
	logic [HADDR_BITS-1:0]   wr_addr;

	// combinational
	logic                    item_beat;
	logic                    out_free;
	logic [FSIZE_BITS-1:0]   fsize;
	logic [CHAN_BITS-1:0]    ch_sel;
	logic                    fend_sel;
	logic signed [SAMPLE_BITS:0] x_wide;
	sample_t                 x_sat;
	coef_t                   mul_a;
	coef_t                   mul_b;
	logic signed [PROD_BITS-1:0] mul_p;
	logic signed [ACC_BITS-1:0]  prod_term;
	logic signed [ACC_BITS-1:0]  rnd_sum;
	logic signed [ACC_BITS-1:0]  rnd_shift;
	logic signed [PROD_BITS-1:0] scale_sum;
	logic signed [PROD_BITS-1:0] y_wide;
	sample_t                 y_sat;

	assign cfg_ready  = 1'b1;
	assign item_ready = (state_q == ST_IDLE);
	assign item_beat  = item_valid && item_ready;
	assign out_free   = !res_vld_q || result_ready;

	// Pick the channel: a counter left beyond the frame by a mode change restarts at zero.
	assign fsize    = frame_size(mode_q);
	assign ch_sel   = ({1'b0, chan_cnt_q} < fsize) ? chan_cnt_q : '0;
	assign fend_sel = ({1'b0, ch_sel} == (fsize - FSIZE_BITS'(1)));

	// Add the anti-denormal bias with the current sign, then clamp to the sample range.
	always_comb begin
		if (bias_neg_q)
			x_wide = (SAMPLE_BITS+1)'(sample_in) - $signed({1'b0, {(SAMPLE_BITS-BIAS_BITS){1'b0}}, bias_mag_q});
		else
			x_wide = (SAMPLE_BITS+1)'(sample_in) + $signed({1'b0, {(SAMPLE_BITS-BIAS_BITS){1'b0}}, bias_mag_q});
		if (x_wide[SAMPLE_BITS] != x_wide[SAMPLE_BITS-1])
			x_sat = x_wide[SAMPLE_BITS] ? SAMPLE_MIN : SAMPLE_MAX;
		else
			x_sat = x_wide[SAMPLE_BITS-1:0];
	end

	// An entry never written since reset reads as all zero.
	assign hist = rd_vld_q ? hist_rd_q : '0;

	// Shared multiplier: one product per cycle, operands chosen by the sequencer state and step.
	always_comb begin
		if (state_q == ST_SCALE) begin
			mul_a = coef_q[REG_RECIP_A0];
			mul_b = num_q;
		end else begin
			case (step_q)
				3'd0: begin
					mul_a = coef_q[REG_B0];
					mul_b = COEF_BITS'(x_q);
				end
				3'd1: begin
					mul_a = coef_q[REG_B1];
					mul_b = COEF_BITS'(hist.x1);
				end
				3'd2: begin
					mul_a = coef_q[REG_B2];
					mul_b = COEF_BITS'(hist.x2);
				end
				3'd3: begin
					mul_a = coef_q[REG_A1];
					mul_b = COEF_BITS'(hist.y1);
				end
				default: begin
					mul_a = coef_q[REG_A2];
					mul_b = COEF_BITS'(hist.y2);
				end
			endcase
		end
	end

	assign mul_p     = mul_a * mul_b;
	assign prod_term = ACC_BITS'(prod_s1);

	// Numerator: fold in the last (feedback) product and round by the coefficient fraction.
	assign rnd_sum   = acc_q - prod_term + ACC_HALF;
	assign rnd_shift = rnd_sum >>> COEF_FRAC;

	// Output: round the scaled product and clamp to the sample range.
	assign scale_sum = prod_s1 + PROD_HALF;
	assign y_wide    = scale_sum >>> COEF_FRAC;
	always_comb begin
		if ((&y_wide[PROD_BITS-1:SAMPLE_BITS-1]) || !(|y_wide[PROD_BITS-1:SAMPLE_BITS-1]))
			y_sat = y_wide[SAMPLE_BITS-1:0];
		else
			y_sat = y_wide[PROD_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
	end

	// Shift the history of the channel just filtered.
	assign hist_we    = (state_q == ST_OUT) && out_free;
	assign hist_re    = item_beat;
	assign rd_addr    = ch_sel[HADDR_BITS-1:0];
	assign wr_addr    = ch_q[HADDR_BITS-1:0];
	assign hist_wdata = '{x1: x_q, x2: hist.x1, y1: y_sat, y2: hist.y1};

	// Sequencer, configuration and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			chan_cnt_q   <= '0;
			bias_neg_q   <= 1'b0;
			hist_vld_q   <= '0;
			rd_vld_q     <= 1'b0;
			for (int i = 0; i < NUM_COEFS; i++)
				coef_q[i] <= (i == int'(REG_B0) || i == int'(REG_RECIP_A0)) ?
					COEF_ONE : '0;
			bias_mag_q   <= '0;
			mode_q       <= MODE_MONO;
			res_vld_q    <= 1'b0;
			res_sample_q <= '0;
			res_chan_q   <= '0;
			res_fend_q   <= 1'b0;
			res_blk_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_RECIP_A0:
						coef_q[cfg_index] <= cfg_data;
					REG_BIAS: bias_mag_q <= cfg_data[BIAS_BITS-1:0];
					REG_MODE: mode_q     <= cfg_data[MODE_BITS-1:0];
					default: ;
				endcase
			end

			// drop the result once the consumer takes it, unless a new one lands now
			if (res_vld_q && result_ready && !hist_we)
				res_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (item_beat) begin
						rd_vld_q <= hist_vld_q[rd_addr];
						step_q   <= '0;
						state_q  <= ST_MAC;
						// advance the frame position; flip the bias sign after a full frame
						if (fend_sel) begin
							chan_cnt_q <= '0;
							bias_neg_q <= !bias_neg_q;
						end else begin
							chan_cnt_q <= ch_sel + CHAN_BITS'(1);
						end
					end
				end
				ST_MAC: begin
					if (step_q == LAST_STEP)
						state_q <= ST_RND;
					else
						step_q <= step_q + 3'd1;
				end
				ST_RND: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold here until the result register is free
					if (out_free) begin
						hist_vld_q[wr_addr] <= 1'b1;
						res_vld_q    <= 1'b1;
						res_sample_q <= y_sat;
						res_chan_q   <= ch_q;
						res_fend_q   <= fend_q;
						res_blk_q    <= blk_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (item_beat) begin
			x_q    <= x_sat;
			ch_q   <= ch_sel;
			fend_q <= fend_sel;
			blk_q  <= block_end_in;
		end
		if (state_q == ST_MAC) begin
			prod_s1 <= mul_p;
			// accumulate the product issued on the previous step; a1*y1 subtracts
			if (step_q == 3'd0)
				acc_q <= '0;
			else if (step_q == LAST_STEP)
				acc_q <= acc_q - prod_term;
			else
				acc_q <= acc_q + prod_term;
		end
		if (state_q == ST_RND)
			num_q <= COEF_BITS'(rnd_shift);
		if (state_q == ST_SCALE)
			prod_s1 <= mul_p;
	end

	// History RAM: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[wr_addr] <= hist_wdata;
		if (hist_re)
			hist_rd_q <= hist_mem[rd_addr];
	end

	assign result_valid  = res_vld_q;
	assign sample_out    = res_sample_q;
	assign channel_index = res_chan_q;
	assign frame_end     = res_fend_q;
	assign block_end_out = res_blk_q;

endmodule
